// File: rtl/dra_pkg.sv
`timescale 1ns / 1ps

package dra_pkg;

   localparam logic [1:0] POINTER_TAG   = 2'b11;
   localparam int         HEADER_BYTES  = 12;
   localparam int         QUESTION_TAIL = 4;
   localparam int         ANSWER_FIXED  = 10;
   localparam int         HEADER_COUNTS = 4;

   localparam logic [1:0] STAT_FOUND   = 2'd0;
   localparam logic [1:0] STAT_NONE    = 2'd1;
   localparam logic [1:0] STAT_LONG    = 2'd2;
   localparam logic [1:0] STAT_OVERRUN = 2'd3;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] ipv4_address;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic overflow;
   } job_ctl_type;

   typedef struct packed {
      logic take;
      logic busy;
   } par_ctl_type;

   typedef enum logic [3:0] {
      PS_IDLE,
      PS_HREAD,
      PS_HDATA,
      PS_REC,
      PS_NAME0,
      PS_PTR,
      PS_LABEL,
      PS_ANS,
      PS_DLEN0,
      PS_DLEN1,
      PS_AREAD,
      PS_ADATA
   } parse_state_type;

endpackage

// File: rtl/dra_ram.sv
`timescale 1ns / 1ps

module dra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/dra_loader.sv
`timescale 1ns / 1ps

module dra_loader #(
   parameter int PACKET_BYTES = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  dra_pkg::req_type                    req_data,
   output dra_pkg::job_ctl_type                job_ctl,
   output logic [$clog2(PACKET_BYTES+1)-1:0]   job_count,
   input  dra_pkg::par_ctl_type                par_ctl,
   output logic                                wr_en,
   output logic [$clog2(PACKET_BYTES)-1:0]     wr_addr,
   output logic [7:0]                          wr_data
);

   import dra_pkg::*;

   localparam int CW = $clog2(PACKET_BYTES + 1);
   localparam int AW = $clog2(PACKET_BYTES);

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          job_valid_ff, job_valid_in;
   logic          job_ovf_ff, job_ovf_in;
   logic [CW-1:0] job_count_ff, job_count_in;
   logic          accept;
   logic          room;

   assign full   = job_valid_ff | par_ctl.busy;
   assign accept = push & ~full;
   assign room   = count_ff < CW'(PACKET_BYTES);

   assign wr_en   = accept & room;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = req_data.packet_byte;

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      job_valid_in = job_valid_ff & ~par_ctl.take;
      job_ovf_in   = job_ovf_ff;
      job_count_in = job_count_ff;
      if (accept) begin
         if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (req_data.last_byte) begin
            job_valid_in = 1'b1;
            job_ovf_in   = ovf_in;
            job_count_in = count_in;
            count_in     = '0;
            ovf_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         job_valid_ff <= job_valid_in;
      end
      job_ovf_ff   <= job_ovf_in;
      job_count_ff <= job_count_in;
   end

   assign job_ctl.valid    = job_valid_ff;
   assign job_ctl.overflow = job_ovf_ff;
   assign job_count        = job_count_ff;

endmodule

// File: rtl/dra_parser.sv
`timescale 1ns / 1ps

module dra_parser #(
   parameter int PACKET_BYTES = 512,
   parameter int NAME_LIMIT   = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dra_pkg::job_ctl_type                job_ctl,
   input  logic [$clog2(PACKET_BYTES+1)-1:0]   job_count,
   output dra_pkg::par_ctl_type                par_ctl,
   output logic                                rd_en,
   output logic [$clog2(PACKET_BYTES)-1:0]     rd_addr,
   input  logic [7:0]                          rd_data,
   input  logic                                pop,
   output logic                                empty,
   output dra_pkg::rsp_type                    rsp_data
);

   import dra_pkg::*;

   localparam int CW    = $clog2(PACKET_BYTES + 1);
   localparam int AW    = $clog2(PACKET_BYTES);
   localparam int POS_W = CW + 17;
   localparam int NW    = $clog2(NAME_LIMIT + 257);

   parse_state_type state_ff, state_in;

   logic [POS_W-1:0] cursor_ff, cursor_in;
   logic [POS_W-1:0] walk_ff, walk_in;
   logic [NW-1:0]    ncount_ff, ncount_in;
   logic             first_ff, first_in;
   logic             ptr_ff, ptr_in;
   logic [7:0]       b0_ff, b0_in;
   logic [7:0]       d0_ff, d0_in;
   logic [15:0]      rec_ff, rec_in;
   logic [15:0]      an_ff, an_in;
   logic             answers_ff, answers_in;
   logic [1:0]       idx_ff, idx_in;
   logic [31:0]      addr_ff, addr_in;
   logic [CW-1:0]    limit_ff, limit_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic             take;
   logic             bad_job;
   logic [POS_W-1:0] rd_pos;
   logic             rd_req;
   logic             rd_ok;
   logic             fin;
   logic [1:0]       fin_status;
   logic [NW-1:0]    cnt_new;
   logic             too_long;
   logic [POS_W-1:0] walk_next;
   logic [POS_W-1:0] name_end;
   logic [15:0]      dlen;
   logic             is_ptr;

   assign take    = (state_ff == PS_IDLE) & job_ctl.valid & (~out_valid_ff | pop);
   assign bad_job = job_ctl.overflow | (job_count < CW'(HEADER_BYTES));
   assign is_ptr  = rd_data[7:6] == POINTER_TAG;

   assign cnt_new   = ncount_ff + NW'(rd_data) + NW'(!first_ff);
   assign too_long  = cnt_new >= NW'(NAME_LIMIT);
   assign walk_next = walk_ff + POS_W'(rd_data) + POS_W'(1);
   assign name_end  = ptr_ff ? cursor_ff + POS_W'(2) : walk_ff + POS_W'(1);
   assign dlen      = {d0_ff, rd_data};
   assign rd_ok     = rd_pos < POS_W'(limit_ff);

   always_comb begin
      rd_pos     = cursor_ff;
      rd_req     = 1'b0;
      fin        = 1'b0;
      fin_status = STAT_OVERRUN;
      case (state_ff)
         PS_IDLE: begin
            fin = take & bad_job;
         end
         PS_HREAD: begin
            rd_pos = POS_W'(HEADER_COUNTS) + POS_W'(idx_ff);
            rd_req = 1'b1;
         end
         PS_REC: begin
            if (rec_ff != '0) begin
               rd_req = 1'b1;
            end else if (answers_ff) begin
               fin        = 1'b1;
               fin_status = STAT_NONE;
            end
         end
         PS_NAME0: begin
            rd_pos = is_ptr ? cursor_ff + POS_W'(1) : cursor_ff;
            rd_req = 1'b1;
         end
         PS_PTR: begin
            rd_pos = POS_W'({b0_ff[5:0], rd_data});
            rd_req = 1'b1;
         end
         PS_LABEL: begin
            if (rd_data != '0) begin
               if (too_long) begin
                  fin        = 1'b1;
                  fin_status = STAT_LONG;
               end else begin
                  rd_pos = walk_next;
                  rd_req = 1'b1;
               end
            end
         end
         PS_ANS: begin
            rd_pos = cursor_ff + POS_W'(8);
            rd_req = 1'b1;
         end
         PS_DLEN0: begin
            rd_pos = cursor_ff + POS_W'(9);
            rd_req = 1'b1;
         end
         PS_AREAD: begin
            rd_pos = cursor_ff + POS_W'(idx_ff);
            rd_req = 1'b1;
         end
         PS_ADATA: begin
            if (idx_ff == 2'd3) begin
               fin        = 1'b1;
               fin_status = STAT_FOUND;
            end
         end
         default: begin
            rd_req = 1'b0;
         end
      endcase
      if (rd_req & ~rd_ok) begin
         fin        = 1'b1;
         fin_status = STAT_OVERRUN;
      end
   end

   assign rd_en   = rd_req & rd_ok;
   assign rd_addr = rd_pos[AW-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PS_IDLE: begin
            if (take & ~bad_job) begin
               state_in = PS_HREAD;
            end
         end
         PS_HREAD: state_in = PS_HDATA;
         PS_HDATA: state_in = (idx_ff == 2'd3) ? PS_REC : PS_HREAD;
         PS_REC: begin
            if (fin) begin
               state_in = PS_IDLE;
            end else if (rec_ff != '0) begin
               state_in = PS_NAME0;
            end
         end
         PS_NAME0: state_in = fin ? PS_IDLE : (is_ptr ? PS_PTR : PS_LABEL);
         PS_PTR:   state_in = fin ? PS_IDLE : PS_LABEL;
         PS_LABEL: begin
            if (rd_data == '0) begin
               state_in = answers_ff ? PS_ANS : PS_REC;
            end else if (fin) begin
               state_in = PS_IDLE;
            end
         end
         PS_ANS:   state_in = fin ? PS_IDLE : PS_DLEN0;
         PS_DLEN0: state_in = fin ? PS_IDLE : PS_DLEN1;
         PS_DLEN1: state_in = (dlen == 16'd4) ? PS_AREAD : PS_REC;
         PS_AREAD: state_in = fin ? PS_IDLE : PS_ADATA;
         PS_ADATA: state_in = fin ? PS_IDLE : PS_AREAD;
         default:  state_in = PS_IDLE;
      endcase
   end

   always_comb begin
      cursor_in  = cursor_ff;
      walk_in    = walk_ff;
      ncount_in  = ncount_ff;
      first_in   = first_ff;
      ptr_in     = ptr_ff;
      b0_in      = b0_ff;
      d0_in      = d0_ff;
      rec_in     = rec_ff;
      an_in      = an_ff;
      answers_in = answers_ff;
      idx_in     = idx_ff;
      addr_in    = addr_ff;
      limit_in   = limit_ff;
      case (state_ff)
         PS_IDLE: begin
            limit_in   = job_count;
            idx_in     = '0;
            answers_in = 1'b0;
         end
         PS_HDATA: begin
            addr_in = {addr_ff[23:0], rd_data};
            idx_in  = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               rec_in    = addr_ff[23:8];
               an_in     = {addr_ff[7:0], rd_data};
               cursor_in = POS_W'(HEADER_BYTES);
            end
         end
         PS_REC: begin
            if ((rec_ff == '0) & ~answers_ff) begin
               answers_in = 1'b1;
               rec_in     = an_ff;
            end
         end
         PS_NAME0: begin
            b0_in     = rd_data;
            ptr_in    = is_ptr;
            walk_in   = cursor_ff;
            first_in  = 1'b1;
            ncount_in = '0;
         end
         PS_PTR: begin
            walk_in = POS_W'({b0_ff[5:0], rd_data});
         end
         PS_LABEL: begin
            if (rd_data == '0) begin
               if (answers_ff) begin
                  cursor_in = name_end;
               end else begin
                  cursor_in = name_end + POS_W'(QUESTION_TAIL);
                  rec_in    = rec_ff - 16'd1;
               end
            end else begin
               ncount_in = cnt_new;
               first_in  = 1'b0;
               walk_in   = walk_next;
            end
         end
         PS_DLEN0: begin
            d0_in = rd_data;
         end
         PS_DLEN1: begin
            idx_in = '0;
            if (dlen == 16'd4) begin
               cursor_in = cursor_ff + POS_W'(ANSWER_FIXED);
            end else begin
               cursor_in = cursor_ff + POS_W'(ANSWER_FIXED) + POS_W'(dlen);
               rec_in    = rec_ff - 16'd1;
            end
         end
         PS_ADATA: begin
            addr_in = {addr_ff[23:0], rd_data};
            idx_in  = idx_ff + 2'd1;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff & ~pop;
      out_in       = out_ff;
      if (fin) begin
         out_valid_in        = 1'b1;
         out_in.status       = fin_status;
         out_in.found        = fin_status == STAT_FOUND;
         out_in.ipv4_address = (fin_status == STAT_FOUND) ? {addr_ff[23:0], rd_data} : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PS_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cursor_ff  <= cursor_in;
      walk_ff    <= walk_in;
      ncount_ff  <= ncount_in;
      first_ff   <= first_in;
      ptr_ff     <= ptr_in;
      b0_ff      <= b0_in;
      d0_ff      <= d0_in;
      rec_ff     <= rec_in;
      an_ff      <= an_in;
      answers_ff <= answers_in;
      idx_ff     <= idx_in;
      addr_ff    <= addr_in;
      limit_ff   <= limit_in;
      out_ff     <= out_in;
   end

   assign par_ctl.take = take;
   assign par_ctl.busy = state_ff != PS_IDLE;
   assign empty        = ~out_valid_ff;
   assign rsp_data     = out_ff;

endmodule

// File: rtl/dns_response_address_extract.sv
`timescale 1ns / 1ps
// Packet bytes are taken one per cycle while no earlier packet waits for or is in its parse.
// The parse reads the store byte by byte: the header counts, then each name label by label
// or through its pointer, the data length of each answer, the turn to the answers, then the
// four address bytes, or it ends when none is found; the result is registered and may wait
// in its register while the next packet loads.
// Synchronous active-high reset empties the loader, the parser and the result register.

module dns_response_address_extract #(
   parameter int PACKET_BYTES = 512,
   parameter int NAME_LIMIT   = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  dra_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output dra_pkg::rsp_type rsp_data
);

   import dra_pkg::*;

   localparam int CW = $clog2(PACKET_BYTES + 1);
   localparam int AW = $clog2(PACKET_BYTES);

   job_ctl_type   job_ctl;
   logic [CW-1:0] job_count;
   par_ctl_type   par_ctl;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   dra_ram #(
      .WIDTH(8),
      .DEPTH(PACKET_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dra_loader #(
      .PACKET_BYTES(PACKET_BYTES)
   ) u_loader (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .job_ctl   (job_ctl),
      .job_count (job_count),
      .par_ctl   (par_ctl),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   dra_parser #(
      .PACKET_BYTES(PACKET_BYTES),
      .NAME_LIMIT  (NAME_LIMIT)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .job_ctl   (job_ctl),
      .job_count (job_count),
      .par_ctl   (par_ctl),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

endmodule

// File: verif/tb_dns_response_address_extract.sv
`timescale 1ns / 1ps

module tb_dns_response_address_extract;
   import dra_pkg::*;

   localparam int STORE_BYTES = 512;
   localparam int NAME_MAX    = 512;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_CYCLES = 1000;
   localparam int DRAIN       = 200;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   dns_response_address_extract #(
      .PACKET_BYTES(STORE_BYTES),
      .NAME_LIMIT(NAME_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   logic [7:0] build_q[$];
   req_type    byte_pending_q[$];
   rsp_type    reply_expect_q[$];

   logic [7:0] stored_bytes[STORE_BYTES];
   int         stored_len     = 0;
   bit         store_overflow = 1'b0;

   int      error_count   = 0;
   int      beat_count    = 0;
   int      result_count  = 0;
   int      packets_built = 0;
   int      cycle_count   = 0;
   int      status_tally[4];
   int      burst_left    = 16;
   int      gap_left      = 0;
   int      hold_left     = 0;
   bit      hold_done     = 1'b0;
   int      rx_tick       = 0;
   int      pop_pct       = 100;
   rsp_type want;

   task automatic note_error(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic bit peek_stored(input int pos, output logic [7:0] val);
      val = '0;
      if (pos >= stored_len) begin
         return 1'b0;
      end
      val = stored_bytes[pos];
      return 1'b1;
   endfunction

   function automatic logic [1:0] walk_dotted(input int pos, output int stop);
      logic [7:0] lb;
      int         chars;
      int         lv;
      bit         first;
      chars = 0;
      first = 1'b1;
      stop  = 0;
      forever begin
         if (!peek_stored(pos, lb)) begin
            return STAT_OVERRUN;
         end
         lv = lb;
         if (lv == 0) begin
            break;
         end
         if (!first) begin
            if (chars + lv >= NAME_MAX) begin
               return STAT_LONG;
            end
            chars++;
         end
         first = 1'b0;
         if (chars + lv >= NAME_MAX) begin
            return STAT_LONG;
         end
         chars += lv;
         pos += lv + 1;
      end
      stop = pos + 1;
      return STAT_FOUND;
   endfunction

   function automatic logic [1:0] pass_name(inout int cur);
      logic [7:0] b0;
      logic [7:0] b1;
      int         stop;
      logic [1:0] st;
      if (!peek_stored(cur, b0)) begin
         return STAT_OVERRUN;
      end
      if (b0[7:6] == POINTER_TAG) begin
         if (!peek_stored(cur + 1, b1)) begin
            return STAT_OVERRUN;
         end
         st = walk_dotted(int'({b0[5:0], b1}), stop);
         if (st == STAT_FOUND) begin
            cur += 2;
         end
         return st;
      end
      st = walk_dotted(cur, stop);
      if (st == STAT_FOUND) begin
         cur = stop;
      end
      return st;
   endfunction

   function automatic logic [1:0] decode_reply(output logic [31:0] addr);
      logic [7:0] cnt[4];
      logic [7:0] d[4];
      int         cur;
      int         left;
      int         dl;
      int         i;
      logic [1:0] st;
      addr = '0;
      for (i = 0; i < HEADER_COUNTS; i++) begin
         if (!peek_stored(4 + i, cnt[i])) begin
            return STAT_OVERRUN;
         end
      end
      if (stored_len < HEADER_BYTES) begin
         return STAT_OVERRUN;
      end
      cur = HEADER_BYTES;
      for (left = int'({cnt[0], cnt[1]}); left > 0; left--) begin
         st = pass_name(cur);
         if (st != STAT_FOUND) begin
            return st;
         end
         cur += QUESTION_TAIL;
      end
      for (left = int'({cnt[2], cnt[3]}); left > 0; left--) begin
         st = pass_name(cur);
         if (st != STAT_FOUND) begin
            return st;
         end
         if (!peek_stored(cur + 8, d[0]) || !peek_stored(cur + 9, d[1])) begin
            return STAT_OVERRUN;
         end
         dl = int'({d[0], d[1]});
         cur += ANSWER_FIXED;
         if (dl == 4) begin
            for (i = 0; i < 4; i++) begin
               if (!peek_stored(cur + i, d[i])) begin
                  return STAT_OVERRUN;
               end
            end
            addr = {d[0], d[1], d[2], d[3]};
            return STAT_FOUND;
         end
         cur += dl;
      end
      return STAT_NONE;
   endfunction

   task automatic absorb_beat(input req_type r);
      rsp_type     exp;
      logic [31:0] a;
      logic [1:0]  st;
      if (stored_len < STORE_BYTES) begin
         stored_bytes[stored_len] = r.packet_byte;
         stored_len++;
      end else begin
         store_overflow = 1'b1;
      end
      if (!r.last_byte) begin
         return;
      end
      a = '0;
      if (store_overflow) begin
         st = STAT_OVERRUN;
      end else begin
         st = decode_reply(a);
      end
      if (st != STAT_FOUND) begin
         a = '0;
      end
      exp.found        = (st == STAT_FOUND);
      exp.ipv4_address = a;
      exp.status       = st;
      reply_expect_q.insert(reply_expect_q.size(), exp);
      status_tally[st]++;
      stored_len     = 0;
      store_overflow = 1'b0;
   endtask

   task automatic add_byte(input int b);
      build_q.insert(build_q.size(), b[7:0]);
   endtask

   task automatic add_word(input int v);
      add_byte(v >> 8);
      add_byte(v);
   endtask

   task automatic add_fill(input int n);
      repeat (n) add_byte($urandom_range(0, 255));
   endtask

   task automatic start_reply(input int qd, input int an);
      build_q.delete();
      add_fill(4);
      add_word(qd);
      add_word(an);
      add_fill(4);
   endtask

   task automatic add_labels(input int n, input int lo, input int hi);
      int len;
      repeat (n) begin
         len = $urandom_range(lo, hi);
         add_byte(len);
         add_fill(len);
      end
      add_byte(0);
   endtask

   task automatic add_ptr(input int off);
      add_word(int'({POINTER_TAG, off[13:0]}));
   endtask

   task automatic add_rr(input int dl);
      add_ptr(HEADER_BYTES);
      add_fill(ANSWER_FIXED - 2);
      add_word(dl);
   endtask

   task automatic ship_reply();
      req_type r;
      foreach (build_q[i]) begin
         r.packet_byte = build_q[i];
         r.last_byte   = (i == build_q.size() - 1);
         byte_pending_q.insert(byte_pending_q.size(), r);
      end
      packets_built++;
   endtask

   task automatic random_reply();
      int kind;
      int qd;
      int an;
      int dl;
      int span;
      int pos;
      kind = $urandom_range(0, 99);
      if (kind < 3) begin
         start_reply(1, $urandom_range(0, 1));
         span = 0;
         while (span < 260) begin
            dl = $urandom_range(20, 120);
            add_byte(dl);
            add_fill(dl);
            span += dl + 1;
         end
         add_byte($urandom_range(100, 255));
         add_fill($urandom_range(0, 3));
      end else if (kind < 4) begin
         start_reply(1, 1);
         add_fill(STORE_BYTES + $urandom_range(1, 8) - build_q.size());
      end else if (kind < 16) begin
         build_q.delete();
         add_fill($urandom_range(1, 40));
      end else begin
         qd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : $urandom_range(0, 2);
         an = $urandom_range(0, 4);
         start_reply(qd, an);
         for (int q = 0; q < qd; q++) begin
            if (q == 0 || $urandom_range(0, 1) == 0) begin
               add_labels($urandom_range(0, 3), 1, 12);
            end else begin
               add_ptr(HEADER_BYTES);
            end
            add_fill(QUESTION_TAIL);
         end
         repeat (an) begin
            if (qd > 0 && $urandom_range(0, 9) < 7) begin
               add_ptr(HEADER_BYTES);
            end else begin
               add_labels($urandom_range(0, 2), 1, 12);
            end
            add_fill(ANSWER_FIXED - 2);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: dl = 4;
               5, 6:          dl = 16;
               default:       dl = $urandom_range(0, 10);
            endcase
            add_word(dl);
            add_fill(dl);
         end
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            span = $urandom_range(1, build_q.size());
            while (build_q.size() > span) void'(build_q.pop_back());
         end else if (kind < 25) begin
            add_fill($urandom_range(1, 8));
         end else if (kind < 35) begin
            pos = $urandom_range(0, build_q.size() - 1);
            build_q[pos] = 8'($urandom_range(0, 255));
         end
      end
      ship_reply();
   endtask

   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left--;
         push <= 1'b0;
      end else if (byte_pending_q.size() == 0) begin
         push <= 1'b0;
      end else begin
         push     <= 1'b1;
         req_data <= byte_pending_q[0];
         burst_left--;
         if (burst_left <= 0) begin
            if ($urandom_range(0, 7) == 0) begin
               burst_left = $urandom_range(100, 300);
               gap_left   = 0;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         if (!hold_done && beat_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         rx_tick++;
         if (rx_tick % 200 == 0) begin
            case ($urandom_range(0, 3))
               0:       pop_pct = 100;
               1:       pop_pct = 75;
               2:       pop_pct = 35;
               default: pop_pct = 8;
            endcase
         end
         pop <= (hold_left == 0) && ($urandom_range(0, 99) < pop_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            absorb_beat(req_data);
            void'(byte_pending_q.pop_front());
            beat_count++;
         end
         if (pop && !empty) begin
            if (reply_expect_q.size() == 0) begin
               note_error($sformatf("result %h with nothing expected", rsp_data));
            end else begin
               want = reply_expect_q.pop_front();
               if (rsp_data.found !== want.found) begin
                  note_error($sformatf("found %b, expected %b", rsp_data.found, want.found));
               end
               if (rsp_data.ipv4_address !== want.ipv4_address) begin
                  note_error($sformatf("address %h, expected %h",
                                       rsp_data.ipv4_address, want.ipv4_address));
               end
               if (rsp_data.status !== want.status) begin
                  note_error($sformatf("status %0d, expected %0d",
                                       rsp_data.status, want.status));
               end
               result_count++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, reply_expect_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int rand_bytes;
      int rand_packets;
      foreach (status_tally[i]) status_tally[i] = 0;

      // Header too short to hold the counts, one byte short of a full header, then a bare header.
      build_q.delete();
      add_byte(8'hFF);
      ship_reply();
      start_reply(0, 0);
      void'(build_q.pop_back());
      ship_reply();
      start_reply(0, 0);
      ship_reply();

      // Address of all ones, then a 16-byte answer ahead of an all-zero address.
      start_reply(1, 1);
      add_labels(2, 1, 63);
      add_fill(QUESTION_TAIL);
      add_rr(4);
      repeat (4) add_byte(8'hFF);
      ship_reply();
      start_reply(1, 2);
      add_labels(1, 1, 8);
      add_fill(QUESTION_TAIL);
      add_rr(16);
      add_fill(16);
      add_rr(4);
      repeat (4) add_byte(8'h00);
      ship_reply();

      // Root name with the address data cut short.
      start_reply(1, 1);
      add_byte(0);
      add_fill(QUESTION_TAIL);
      add_rr(4);
      add_fill(3);
      ship_reply();

      // Data length field missing its second byte.
      start_reply(1, 1);
      add_labels(1, 1, 8);
      add_fill(QUESTION_TAIL);
      add_ptr(HEADER_BYTES);
      add_fill(ANSWER_FIXED - 2);
      add_byte(0);
      ship_reply();

      // Pointer without its second byte, and a pointer far outside the packet.
      start_reply(1, 0);
      add_byte(8'hC0);
      ship_reply();
      start_reply(1, 0);
      add_ptr(16'h3FFF);
      add_fill(QUESTION_TAIL);
      ship_reply();

      // A pointer target starting with a tag-like byte is walked as a long label.
      start_reply(1, 1);
      add_byte(1);
      add_byte(8'hC0);
      add_byte(0);
      add_fill(QUESTION_TAIL);
      add_ptr(HEADER_BYTES + 1);
      add_fill(ANSWER_FIXED - 2);
      add_word(4);
      add_fill(4);
      while (build_q.size() < 210) add_byte(0);
      ship_reply();

      // Dotted length one short of the limit, then exactly at it.
      for (int k = 253; k <= 254; k++) begin
         start_reply(1, 0);
         repeat (2) begin
            add_byte(128);
            add_fill(128);
         end
         add_byte(k);
         ship_reply();
      end

      // Largest record counts run off the end of the packet.
      start_reply(16'hFFFF, 16'hFFFF);
      repeat (6) begin
         add_byte(0);
         add_fill(QUESTION_TAIL);
      end
      ship_reply();

      // Answer without questions, named by labels.
      start_reply(0, 1);
      add_labels(2, 1, 8);
      add_fill(ANSWER_FIXED - 2);
      add_word(4);
      add_fill(4);
      ship_reply();

      // Store filled exactly, then by one byte too many.
      for (int k = 0; k < 2; k++) begin
         start_reply(1, 1);
         add_labels(1, 1, 8);
         add_fill(QUESTION_TAIL);
         add_rr(4);
         add_fill(4);
         add_fill(STORE_BYTES + k - build_q.size());
         ship_reply();
      end

      rand_bytes   = 0;
      rand_packets = 0;
      while (rand_bytes < 500 || rand_packets < 8) begin
         random_reply();
         rand_bytes += build_q.size();
         rand_packets++;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_pending_q.size() != 0) @(negedge clock);
      while (reply_expect_q.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);

      if (reply_expect_q.size() != 0) begin
         note_error($sformatf("%0d results never arrived", reply_expect_q.size()));
      end
      $display("Sent %0d packets in %0d beats: %0d with an address, %0d without one,",
               packets_built, beat_count, status_tally[STAT_FOUND], status_tally[STAT_NONE]);
      $display("%0d with names too long, %0d overruns; %0d results checked, %0d mismatches.",
               status_tally[STAT_LONG], status_tally[STAT_OVERRUN], result_count, error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
